// ===== hdl/tgag_pkg.sv =====
// ----------------------------------------------------------------------------
// Tensor gather address generator package
// Shared widths, register indexes and the odometer status type.
// ----------------------------------------------------------------------------
package tgag_pkg;

	// Number of coordinate digits kept by the odometer.
	localparam int AXES = 4;

	// Field widths.
	localparam int COORD_W  = 16;
	localparam int STRIDE_W = 32;
	localparam int COUNT_W  = 32;
	localparam int INDEX_W  = 64;
	localparam int OFFSET_W = 50;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GATHER_AXIS      = 4'd0,
		CFG_SOURCE_AXIS_SIZE = 4'd1,
		CFG_OUTPUT_EXTENTS   = 4'd2,
		CFG_ELEMENT_COUNT    = 4'd3,
		CFG_STRIDE_AXIS0     = 4'd4,
		CFG_STRIDE_AXIS1     = 4'd5,
		CFG_STRIDE_AXIS2     = 4'd6,
		CFG_STRIDE_AXIS3     = 4'd7
	} cfg_reg_t;

	typedef logic [COORD_W-1:0] coord_t;

	// Current output position as seen by the address datapath.
	typedef struct packed {
		coord_t [AXES-1:0] coord;
		logic              last;
	} odo_status_t;

endpackage

// ===== hdl/tgag_odometer.sv =====
// ----------------------------------------------------------------------------
// Tensor gather odometer
// Row-major coordinate counter over the output extents, with element count
// tracking and last-element detection.
// ----------------------------------------------------------------------------
module tgag_odometer #(
	parameter int MAX_AXES = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic [tgag_pkg::AXES*16-1:0]      output_extents,
	input  logic [tgag_pkg::COUNT_W-1:0]      element_count,
	output tgag_pkg::odo_status_t             status
);

	localparam int FIRST_AXIS = tgag_pkg::AXES - MAX_AXES;

	tgag_pkg::coord_t [tgag_pkg::AXES-1:0] coord_q;
	tgag_pkg::coord_t [tgag_pkg::AXES-1:0] coord_next;
	logic [tgag_pkg::COUNT_W-1:0]          position_q;
	logic [tgag_pkg::COUNT_W-1:0]          count_eff;
	logic                                  last;

	// A zero count behaves like a count of one.
	always_comb begin
		count_eff = (element_count == '0) ? tgag_pkg::COUNT_W'(1) : element_count;
		last      = (position_q >= (count_eff - tgag_pkg::COUNT_W'(1)));
	end

	// Ripple carry from the innermost axis outward; inactive axes stop the carry.
	always_comb begin
		logic                    carry;
		logic [tgag_pkg::COORD_W:0] bumped;
		tgag_pkg::coord_t        ext;
		carry = 1'b1;
		for (int k = tgag_pkg::AXES - 1; k >= 0; k--) begin
			ext    = output_extents[16*(tgag_pkg::AXES-1-k) +: 16];
			bumped = {1'b0, coord_q[k]} + 17'd1;
			coord_next[k] = coord_q[k];
			if (k < FIRST_AXIS) begin
				carry = 1'b0;
			end else if (carry) begin
				if (bumped < {1'b0, ext}) begin
					coord_next[k] = bumped[tgag_pkg::COORD_W-1:0];
					carry = 1'b0;
				end else begin
					coord_next[k] = '0;
				end
			end
		end
	end

	// Counter state advances once per accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_q    <= '0;
			position_q <= '0;
		end else if (advance) begin
			if (last) begin
				coord_q    <= '0;
				position_q <= '0;
			end else begin
				coord_q    <= coord_next;
				position_q <= position_q + tgag_pkg::COUNT_W'(1);
			end
		end
	end

	assign status.coord = coord_q;
	assign status.last  = last;

endmodule

// ===== hdl/tensor_gather_address_generator_unit.sv =====
// ----------------------------------------------------------------------------
// Tensor gather address generator
// Turns a stream of gather indexes into input element offsets for a
// gather along one axis of a tensor of up to four axes.
// ----------------------------------------------------------------------------
// One request per output element, in row-major output order, yields one
// result of read_offset, out_of_range and last_element. The unit takes a new
// request every cycle while in_stall is low, and passes each result first
// through the input register, where the odometer coordinates and the index
// range check are captured, then through the four 16x32 stride multipliers
// and their adder into the output register. Stalls on the result side hold
// both stages. Configuration writes are always accepted (cfg_ready is tied
// high) and take effect at once; they are meant to be made only while no
// request is in flight. Unused leading axes should be set up with extent 1
// and stride 0.
// ----------------------------------------------------------------------------
module tensor_gather_address_generator_unit #(
	parameter int MAX_AXES = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Index request channel.
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [tgag_pkg::INDEX_W-1:0] index_value,
	// Result channel.
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tgag_pkg::OFFSET_W-1:0]       read_offset,
	output logic                                out_of_range,
	output logic                                last_element,
	// Configuration write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tgag_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tgag_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int FIRST_AXIS = tgag_pkg::AXES - MAX_AXES;

	// Configuration registers.
	logic [1:0]                              gather_axis_q;
	logic [15:0]                             source_axis_size_q;
	logic [63:0]                             output_extents_q;
	logic [tgag_pkg::COUNT_W-1:0]            element_count_q;
	logic [tgag_pkg::AXES-1:0][tgag_pkg::STRIDE_W-1:0] stride_q;

	// Pipeline state.
	logic                                    valid_s1;
	tgag_pkg::coord_t [tgag_pkg::AXES-1:0]   digit_s1;
	logic                                    bad_s1;
	logic                                    last_s1;
	logic                                    valid_s2;
	logic [tgag_pkg::OFFSET_W-1:0]           offset_s2;
	logic                                    bad_s2;
	logic                                    last_s2;

	logic                                    load_s2;
	logic                                    load_s1;
	logic                                    in_accept;
	logic                                    bad_in;
	tgag_pkg::coord_t [tgag_pkg::AXES-1:0]   digit_in;
	logic [tgag_pkg::OFFSET_W-1:0]           offset_sum;
	tgag_pkg::odo_status_t                   odo_status;

	assign cfg_ready = 1'b1;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gather_axis_q      <= 2'd3;
			source_axis_size_q <= 16'd1;
			output_extents_q   <= 64'h0001_0001_0001_0001;
			element_count_q    <= 32'd1;
			stride_q[0]        <= 32'd0;
			stride_q[1]        <= 32'd0;
			stride_q[2]        <= 32'd0;
			stride_q[3]        <= 32'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tgag_pkg::CFG_GATHER_AXIS:      gather_axis_q      <= cfg_data[1:0];
				tgag_pkg::CFG_SOURCE_AXIS_SIZE: source_axis_size_q <= cfg_data[15:0];
				tgag_pkg::CFG_OUTPUT_EXTENTS:   output_extents_q   <= cfg_data;
				tgag_pkg::CFG_ELEMENT_COUNT:    element_count_q    <= cfg_data[31:0];
				tgag_pkg::CFG_STRIDE_AXIS0:     stride_q[0]        <= cfg_data[31:0];
				tgag_pkg::CFG_STRIDE_AXIS1:     stride_q[1]        <= cfg_data[31:0];
				tgag_pkg::CFG_STRIDE_AXIS2:     stride_q[2]        <= cfg_data[31:0];
				tgag_pkg::CFG_STRIDE_AXIS3:     stride_q[3]        <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	// Flow control: each stage loads when the stage after it can move.
	assign load_s2   = !valid_s2 || !out_stall;
	assign load_s1   = !valid_s1 || load_s2;
	assign in_stall  = !load_s1;
	assign in_accept = in_valid && !in_stall;

	tgag_odometer #(
		.MAX_AXES (MAX_AXES)
	) u_odometer (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (in_accept),
		.output_extents (output_extents_q),
		.element_count  (element_count_q),
		.status         (odo_status)
	);

	// Range check and coordinate selection; the index replaces the gather axis.
	always_comb begin
		bad_in = index_value[tgag_pkg::INDEX_W-1] || (|index_value[62:16])
			|| (index_value[15:0] >= source_axis_size_q);
		for (int k = 0; k < tgag_pkg::AXES; k++) begin
			if (k < FIRST_AXIS) begin
				digit_in[k] = '0;
			end else if (gather_axis_q == 2'(k)) begin
				digit_in[k] = index_value[15:0];
			end else begin
				digit_in[k] = odo_status.coord[k];
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			digit_s1 <= digit_in;
			bad_s1   <= bad_in;
			last_s1  <= odo_status.last;
		end
	end

	// Sum of coordinate times stride over the four axes.
	always_comb begin
		logic [47:0] product;
		offset_sum = '0;
		for (int k = 0; k < tgag_pkg::AXES; k++) begin
			product    = digit_s1[k] * stride_q[k];
			offset_sum = offset_sum + tgag_pkg::OFFSET_W'(product);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			offset_s2 <= bad_s1 ? '0 : offset_sum;
			bad_s2    <= bad_s1;
			last_s2   <= last_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign read_offset  = offset_s2;
	assign out_of_range = bad_s2;
	assign last_element = last_s2;

endmodule
